@@ design/gbc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbc_pkg - shared constants and types for the grid border crossing cell
// Field widths, register reset, direction codes and the flag group that
// travels down the divider pipeline.
// ----------------------------------------------------------------------------
package gbc_pkg;

    localparam int FIELD_W        = 32;   // coordinate, border and result fields
    localparam int COORD_BITS_DEF = 32;
    localparam int CELL_SIZE_W    = 31;
    localparam int Q_BITS         = 32;   // quotient bits produced by the divider

    localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_RST = CELL_SIZE_W'(65536);

    localparam logic [Q_BITS-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [Q_BITS-1:0] SAT_NEG = 32'h8000_0000;

    // border direction
    localparam logic OP_COL = 1'b0;
    localparam logic OP_ROW = 1'b1;

    typedef struct packed {
        logic neg;     // quotient is negative: round away from zero on remainder
        logic sat;     // quotient outside the result range
        logic degen;   // parallel segment or zero cell size
    } t_flags;

endpackage : gbc_pkg
`default_nettype wire

@@ design/gbc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbc_front - numerator and denominator pipeline
// Six stages: axis swap and deltas, products, scaling by cell size,
// numerator sum, magnitude and sign, saturation check and divider setup.
// ----------------------------------------------------------------------------
module gbc_front
    import gbc_pkg::*;
#(
    parameter int CW = COORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic                      i_op,
    input  logic [FIELD_W-1:0]        i_start_x,
    input  logic [FIELD_W-1:0]        i_start_y,
    input  logic [FIELD_W-1:0]        i_end_x,
    input  logic [FIELD_W-1:0]        i_end_y,
    input  logic [FIELD_W-1:0]        i_border_index,
    input  logic [CELL_SIZE_W-1:0]    i_grid_step,
    output logic                      o_valid,
    output logic [CW+CELL_SIZE_W-1:0] o_rem,
    output logic [CW+CELL_SIZE_W-1:0] o_den,
    output logic [Q_BITS-1:0]         o_shift,
    output t_flags                    o_flags
);

    localparam int AW    = CW + 1;              // swapped component
    localparam int DW    = CW + 1;              // endpoint delta
    localparam int BW    = FIELD_W + 1;         // border index, negated
    localparam int PW    = 2 * AW;
    localparam int XW    = PW + 1;
    localparam int CDW   = BW + DW;
    localparam int HW    = CDW - Q_BITS;
    localparam int MLW   = CELL_SIZE_W + Q_BITS;
    localparam int MHW   = CELL_SIZE_W + 1 + HW;
    localparam int DEN_W = CW + CELL_SIZE_W;
    localparam int NUM_W = DEN_W + CELL_SIZE_W + 2;
    localparam int MAG_W = NUM_W - 1;

    // ---------------- stage 1: swap axes, deltas
    logic signed [CW-1:0] sx, sy, ex, ey;
    logic signed [BW-1:0] bi;
    logic                 row;

    assign sx  = i_start_x[CW-1:0];
    assign sy  = i_start_y[CW-1:0];
    assign ex  = i_end_x[CW-1:0];
    assign ey  = i_end_y[CW-1:0];
    assign bi  = BW'($signed(i_border_index));
    assign row = (i_op == OP_ROW);

    logic signed [AW-1:0] n1_ax, n1_ay, n1_bx, n1_by, r1_ax, r1_ay, r1_bx, r1_by;
    logic signed [BW-1:0] n1_c, r1_c;
    logic signed [DW-1:0] n1_dx, n1_dy, r1_dx, r1_dy;

    always_comb begin
        n1_ax = row ? -AW'(sy) : AW'(sx);
        n1_ay = row ?  AW'(sx) : AW'(sy);
        n1_bx = row ? -AW'(ey) : AW'(ex);
        n1_by = row ?  AW'(ex) : AW'(ey);
        n1_c  = row ? -bi : bi;
        n1_dx = row ? (DW'(sy) - DW'(ey)) : (DW'(ex) - DW'(sx));
        n1_dy = row ? (DW'(ex) - DW'(sx)) : (DW'(ey) - DW'(sy));
    end

    // ---------------- stage 2: products, |dx|
    logic signed [PW-1:0]  n2_p1, n2_p2, r2_p1, r2_p2;
    logic signed [CDW-1:0] n2_cdy, r2_cdy;
    logic [DW-1:0]         n2_adx_full;
    logic [CW-1:0]         r2_adx;
    logic                  n2_degen, r2_degen, r2_dxneg;

    always_comb begin
        n2_p1       = r1_ay * r1_bx;
        n2_p2       = r1_ax * r1_by;
        n2_cdy      = r1_c * r1_dy;
        n2_adx_full = r1_dx[DW-1] ? (DW'(0) - r1_dx) : r1_dx;
        n2_degen    = (r1_dx == '0) || (i_grid_step == '0);
    end

    // ---------------- stage 3: cross term, scale by cell size
    logic signed [XW-1:0]  n3_cross, r3_cross;
    logic [MLW-1:0]        n3_mlo, r3_mlo;
    logic signed [MHW-1:0] n3_mhi, r3_mhi;
    logic [DEN_W-1:0]      n3_den, r3_den;
    logic                  r3_degen, r3_dxneg;

    always_comb begin
        n3_cross = r2_p1 - r2_p2;
        n3_mlo   = i_grid_step * r2_cdy[Q_BITS-1:0];
        n3_mhi   = $signed({1'b0, i_grid_step}) * $signed(r2_cdy[CDW-1:Q_BITS]);
        n3_den   = i_grid_step * r2_adx;
    end

    // ---------------- stage 4: numerator
    logic [NUM_W-1:0] sum_cross, sum_hi, sum_lo, n4_num, r4_num;
    logic [DEN_W-1:0] r4_den;
    logic             r4_degen, r4_dxneg;

    always_comb begin
        sum_cross = NUM_W'(r3_cross);
        sum_hi    = {r3_mhi[NUM_W-Q_BITS-1:0], {Q_BITS{1'b0}}};
        sum_lo    = NUM_W'(r3_mlo);
        n4_num    = sum_cross + sum_hi + sum_lo;
    end

    // ---------------- stage 5: sign and magnitude (dx sign folded in)
    logic [NUM_W-1:0] n5_full;
    logic [MAG_W-1:0] r5_mag;
    logic [DEN_W-1:0] r5_den;
    logic             n5_neg, r5_neg, r5_degen;

    always_comb begin
        n5_full = r4_num[NUM_W-1] ? (NUM_W'(0) - r4_num) : r4_num;
        n5_neg  = r4_num[NUM_W-1] ^ r4_dxneg;
    end

    // ---------------- stage 6: saturation, split for the divider
    logic [MAG_W-1:0] thr;
    t_flags           n6_flags, r6_flags;
    logic [DEN_W-1:0] r6_rem, r6_den;
    logic [Q_BITS-1:0] r6_shift;

    always_comb begin
        thr            = MAG_W'(r5_den) << (Q_BITS - 1);
        n6_flags.neg   = r5_neg;
        // negative results reach -2^31, positive ones stop at 2^31-1
        n6_flags.sat   = r5_neg ? (r5_mag > thr) : (r5_mag >= thr);
        n6_flags.degen = r5_degen;
    end

    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax    <= n1_ax;
            r1_ay    <= n1_ay;
            r1_bx    <= n1_bx;
            r1_by    <= n1_by;
            r1_c     <= n1_c;
            r1_dx    <= n1_dx;
            r1_dy    <= n1_dy;

            r2_p1    <= n2_p1;
            r2_p2    <= n2_p2;
            r2_cdy   <= n2_cdy;
            r2_adx   <= n2_adx_full[CW-1:0];
            r2_degen <= n2_degen;
            r2_dxneg <= r1_dx[DW-1];

            r3_cross <= n3_cross;
            r3_mlo   <= n3_mlo;
            r3_mhi   <= n3_mhi;
            r3_den   <= n3_den;
            r3_degen <= r2_degen;
            r3_dxneg <= r2_dxneg;

            r4_num   <= n4_num;
            r4_den   <= r3_den;
            r4_degen <= r3_degen;
            r4_dxneg <= r3_dxneg;

            r5_mag   <= n5_full[MAG_W-1:0];
            r5_den   <= r4_den;
            r5_neg   <= n5_neg;
            r5_degen <= r4_degen;

            r6_rem   <= r5_mag[MAG_W-1:Q_BITS];
            r6_shift <= r5_mag[Q_BITS-1:0];
            r6_den   <= r5_den;
            r6_flags <= n6_flags;
        end
    end

    assign o_valid = r6_v;
    assign o_rem   = r6_rem;
    assign o_den   = r6_den;
    assign o_shift = r6_shift;
    assign o_flags = r6_flags;

    // partial remainder must start below the divisor for an in-range quotient
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r6_v && !r6_flags.sat && !r6_flags.degen) |-> (r6_rem < r6_den))
        else $error("divider entry remainder not below divisor");

endmodule : gbc_front
`default_nettype wire

@@ design/gbc_div_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbc_div_step - one restoring division stage
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module gbc_div_step
    import gbc_pkg::*;
#(
    parameter int DEN_W = COORD_BITS_DEF + CELL_SIZE_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DEN_W-1:0]  i_rem,
    input  logic [Q_BITS-1:0] i_shift,
    input  logic [DEN_W-1:0]  i_den,
    input  t_flags            i_flags,
    output logic              o_valid,
    output logic [DEN_W-1:0]  o_rem,
    output logic [Q_BITS-1:0] o_shift,
    output logic [DEN_W-1:0]  o_den,
    output t_flags            o_flags
);

    logic [DEN_W:0]   trial, diff;
    logic             take;
    logic [DEN_W-1:0] n_rem;

    // dividend bits leave at the top of the shift word, quotient bits enter below
    always_comb begin
        trial = {i_rem, i_shift[Q_BITS-1]};
        diff  = trial - {1'b0, i_den};
        take  = (trial >= {1'b0, i_den});
        n_rem = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    logic              r_valid;
    logic [DEN_W-1:0]  r_rem, r_den;
    logic [Q_BITS-1:0] r_shift;
    t_flags            r_flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem   <= n_rem;
            r_shift <= {i_shift[Q_BITS-2:0], take};
            r_den   <= i_den;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_shift = r_shift;
    assign o_den   = r_den;
    assign o_flags = r_flags;

endmodule : gbc_div_step
`default_nettype wire

@@ design/gbc_out.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbc_out - rounding, saturation and output buffer
// Applies floor rounding to the quotient, substitutes saturated and
// degenerate results, and holds results in a two-entry output buffer.
// ----------------------------------------------------------------------------
module gbc_out
    import gbc_pkg::*;
#(
    parameter int DEN_W = COORD_BITS_DEF + CELL_SIZE_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [DEN_W-1:0]   i_rem,
    input  logic [Q_BITS-1:0]  i_quot,
    input  t_flags             i_flags,
    input  logic               i_ready,
    output logic               o_en,
    output logic               o_valid,
    output logic [FIELD_W-1:0] o_cell_index,
    output logic               o_degenerate
);

    logic [FIELD_W-1:0] res_idx;
    logic               res_degen;

    always_comb begin
        res_degen = i_flags.degen;
        if (i_flags.degen) begin
            res_idx = '0;
        end else if (i_flags.sat) begin
            res_idx = i_flags.neg ? SAT_NEG : SAT_POS;
        end else if (i_flags.neg) begin
            // -(q+1) on a remainder, -q otherwise
            res_idx = (i_rem != '0) ? ~i_quot : (~i_quot + 1'b1);
        end else begin
            res_idx = i_quot;
        end
    end

    logic               r_out_v, r_skid_v;
    logic [FIELD_W-1:0] r_out_idx, r_skid_idx;
    logic               r_out_degen, r_skid_degen;
    logic               push, pop;

    // pipeline runs while the skid entry is free
    assign o_en = !r_skid_v;
    assign push = i_valid && !r_skid_v;
    assign pop  = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= push;
            end
        end else if (!r_out_v) begin
            r_out_v <= push;
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_skid_v) begin
            r_out_idx   <= r_skid_idx;
            r_out_degen <= r_skid_degen;
        end else if (pop || !r_out_v) begin
            r_out_idx   <= res_idx;
            r_out_degen <= res_degen;
        end
        if (push && r_out_v && !pop) begin
            r_skid_idx   <= res_idx;
            r_skid_degen <= res_degen;
        end
    end

    assign o_valid      = r_out_v;
    assign o_cell_index = r_out_idx;
    assign o_degenerate = r_out_degen;

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held while output register empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_ready))
        else $error("skid entry filled without a stalled output");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_degen) |-> (r_out_idx == '0))
        else $error("degenerate result with non-zero cell index");

endmodule : gbc_out
`default_nettype wire

@@ design/grid_border_crossing_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// grid_border_crossing_cell - exact cell index at a grid border crossing
// Top level: configuration register, front pipeline, divider chain, output.
// ----------------------------------------------------------------------------
// One request per cycle while o_in_ready is high. There are 39 register
// stages: six stages form the exact numerator and denominator, a chain of
// 32 restoring division stages produces one quotient bit each, and one
// output register applies floor rounding and saturation. The whole
// pipeline advances together; a two-entry output buffer catches the result
// that arrives while the output stalls, so the input is still taken at the
// first stalled edge. Once a result sits in the second entry o_in_ready
// drops until the output register is taken. i_cfg_we updates the cell edge
// length; write it only with no request in flight. A zero cell size or a
// segment parallel to the border returns o_degenerate with o_cell_index zero.
module grid_border_crossing_cell
    import gbc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CELL_SIZE_W-1:0] i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_op,
    input  logic [FIELD_W-1:0]     i_start_x,
    input  logic [FIELD_W-1:0]     i_start_y,
    input  logic [FIELD_W-1:0]     i_end_x,
    input  logic [FIELD_W-1:0]     i_end_y,
    input  logic [FIELD_W-1:0]     i_border_index,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [FIELD_W-1:0]     o_cell_index,
    output logic                   o_degenerate
);

    // only the low COORD_BITS coordinate bits, at most 32, ever count
    localparam int CW    = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int DEN_W = CW + CELL_SIZE_W;

    logic [CELL_SIZE_W-1:0] r_grid_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_step <= CELL_SIZE_RST;
        end else if (i_cfg_we) begin
            r_grid_step <= i_cfg_wdata;
        end
    end

    logic en;

    logic              d_valid [0:Q_BITS];
    logic [DEN_W-1:0]  d_rem   [0:Q_BITS];
    logic [DEN_W-1:0]  d_den   [0:Q_BITS];
    logic [Q_BITS-1:0] d_shift [0:Q_BITS];
    t_flags            d_flags [0:Q_BITS];

    gbc_front #(
        .CW (CW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_in_valid),
        .i_op           (i_op),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_border_index (i_border_index),
        .i_grid_step    (r_grid_step),
        .o_valid        (d_valid[0]),
        .o_rem          (d_rem[0]),
        .o_den          (d_den[0]),
        .o_shift        (d_shift[0]),
        .o_flags        (d_flags[0])
    );

    for (genvar k = 0; k < Q_BITS; k++) begin : g_div
        gbc_div_step #(
            .DEN_W (DEN_W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (d_valid[k]),
            .i_rem   (d_rem[k]),
            .i_shift (d_shift[k]),
            .i_den   (d_den[k]),
            .i_flags (d_flags[k]),
            .o_valid (d_valid[k+1]),
            .o_rem   (d_rem[k+1]),
            .o_shift (d_shift[k+1]),
            .o_den   (d_den[k+1]),
            .o_flags (d_flags[k+1])
        );
    end

    gbc_out #(
        .DEN_W (DEN_W)
    ) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (d_valid[Q_BITS]),
        .i_rem        (d_rem[Q_BITS]),
        .i_quot       (d_shift[Q_BITS]),
        .i_flags      (d_flags[Q_BITS]),
        .i_ready      (i_out_ready),
        .o_en         (en),
        .o_valid      (o_out_valid),
        .o_cell_index (o_cell_index),
        .o_degenerate (o_degenerate)
    );

    assign o_in_ready = en;

endmodule : grid_border_crossing_cell
`default_nettype wire
